// ----- rtl/asui_pkg.sv -----
// asui_pkg: shared sizes, codes and controller/datapath bundles for the array set core
// no dependencies; compiled before every other file of the block

package asui_pkg;

    // set depths and derived widths
    localparam int MAX_A     = 32;
    localparam int MAX_B     = 32;
    localparam int ADDR_W_A  = $clog2(MAX_A);
    localparam int ADDR_W_B  = $clog2(MAX_B);
    localparam int CNT_W     = 6;
    localparam int VAL_W     = 32;
    localparam int IDX_W     = 5;
    localparam int FUNC_W    = 3;
    localparam int STAT_W    = 3;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY_A = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY_B = 1'd1;
    localparam logic [CNT_W-1:0]     CAP_RESET      = 6'd32;

    // operation codes of an input item
    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 3'd0,
        FN_REMOVE = 3'd1,
        FN_LOOKUP = 3'd2,
        FN_LIST   = 3'd3,
        FN_INTER  = 3'd4,
        FN_UNION  = 3'd5
    } t_func;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_EMPTYRES = 3'd5
    } t_status;

    // datapath micro-operations
    typedef enum logic [3:0] {
        DP_NOP       = 4'd0,
        DP_LOAD      = 4'd1,
        DP_SCAN_RD   = 4'd2,
        DP_SCAN_CMP  = 4'd3,
        DP_OUTER_RD  = 4'd4,
        DP_OUTER_KEY = 4'd5,
        DP_OUTER_CLR = 4'd6,
        DP_ADD_WR    = 4'd7,
        DP_REM_RD    = 4'd8,
        DP_REM_WR    = 4'd9,
        DP_EMIT      = 4'd10,
        DP_RESULT    = 4'd11,
        DP_FINISH    = 4'd12
    } t_dp_op;

    // command from controller to datapath
    typedef struct packed {
        t_dp_op  op;
        logic    scan_b;
        logic    outer_b;
        t_status status;
        logic    use_idx;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic scan_done;
        logic hit;
        logic outer_done;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- rtl/asui_in_if.sv -----
// asui_in_if: input item channel of the array set core (valid/ready plus payload)
// depends on asui_pkg for field widths

interface asui_in_if;
    logic                             valid;
    logic                             ready;
    logic [asui_pkg::FUNC_W-1:0]      func;
    logic                             which_set;
    logic signed [asui_pkg::VAL_W-1:0] member_value;

    modport source (output valid, output func, output which_set, output member_value,
                    input ready);
    modport sink   (input valid, input func, input which_set, input member_value,
                    output ready);
endinterface

// ----- rtl/asui_out_if.sv -----
// asui_out_if: result item channel of the array set core (valid/ready plus payload)
// depends on asui_pkg for field widths

interface asui_out_if;
    logic                              valid;
    logic                              ready;
    logic [asui_pkg::STAT_W-1:0]       status;
    logic signed [asui_pkg::VAL_W-1:0] out_value;
    logic [asui_pkg::IDX_W-1:0]        found_index;
    logic [asui_pkg::CNT_W-1:0]        count_a;
    logic [asui_pkg::CNT_W-1:0]        count_b;
    logic                              last;

    modport source (output valid, output status, output out_value, output found_index,
                    output count_a, output count_b, output last, input ready);
    modport sink   (input valid, input status, input out_value, input found_index,
                    input count_a, input count_b, input last, output ready);
endinterface

// ----- rtl/asui_dp.sv -----
// asui_dp: datapath of the array set core: member memories, fills, capacities,
// scan and outer counters, compare, pending item and result register; uses asui_pkg

module asui_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [asui_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [asui_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  asui_pkg::t_dp_cmd                 i_cmd,
    input  logic signed [asui_pkg::VAL_W-1:0] i_in_value,
    input  logic                              i_out_ready,
    output asui_pkg::t_dp_sts                 o_sts,
    output logic                              o_out_valid,
    output logic [asui_pkg::STAT_W-1:0]       o_status,
    output logic signed [asui_pkg::VAL_W-1:0] o_out_value,
    output logic [asui_pkg::IDX_W-1:0]        o_found_index,
    output logic [asui_pkg::CNT_W-1:0]        o_count_a,
    output logic [asui_pkg::CNT_W-1:0]        o_count_b,
    output logic                              o_last
);

    // member memories
    logic signed [asui_pkg::VAL_W-1:0] mem_a [asui_pkg::MAX_A];
    logic signed [asui_pkg::VAL_W-1:0] mem_b [asui_pkg::MAX_B];
    logic signed [asui_pkg::VAL_W-1:0] r_rd_a;
    logic signed [asui_pkg::VAL_W-1:0] r_rd_b;

    // control state
    logic [asui_pkg::CNT_W-1:0] r_fill_a;
    logic [asui_pkg::CNT_W-1:0] r_fill_b;
    logic [asui_pkg::CNT_W-1:0] r_cap_a;
    logic [asui_pkg::CNT_W-1:0] r_cap_b;
    logic [asui_pkg::CNT_W-1:0] r_scan_idx;
    logic [asui_pkg::CNT_W-1:0] r_outer_idx;
    logic                       r_pend_valid;
    logic                       r_out_valid;

    // payload state
    logic signed [asui_pkg::VAL_W-1:0] r_key;
    logic signed [asui_pkg::VAL_W-1:0] r_pend_value;
    logic [asui_pkg::IDX_W-1:0]        r_hit_idx;
    logic [asui_pkg::STAT_W-1:0]       r_out_status;
    logic signed [asui_pkg::VAL_W-1:0] r_out_value;
    logic [asui_pkg::IDX_W-1:0]        r_out_idx;
    logic [asui_pkg::CNT_W-1:0]        r_out_count_a;
    logic [asui_pkg::CNT_W-1:0]        r_out_count_b;
    logic                              r_out_last;

    // selected views
    logic [asui_pkg::CNT_W-1:0]        cap_eff_a;
    logic [asui_pkg::CNT_W-1:0]        cap_eff_b;
    logic [asui_pkg::CNT_W-1:0]        scan_fill;
    logic [asui_pkg::CNT_W-1:0]        scan_cap;
    logic [asui_pkg::CNT_W-1:0]        outer_fill;
    logic signed [asui_pkg::VAL_W-1:0] scan_data;
    logic signed [asui_pkg::VAL_W-1:0] outer_data;
    logic                              hit;

    // memory port controls
    logic                              rd_en;
    logic                              rd_b;
    logic [asui_pkg::CNT_W-1:0]        rd_addr;
    logic                              wr_en;
    logic [asui_pkg::CNT_W-1:0]        wr_addr;
    logic signed [asui_pkg::VAL_W-1:0] wr_data;
    logic                              out_load;

    // capacity clamp and set selection
    always_comb begin
        cap_eff_a  = (r_cap_a > asui_pkg::CNT_W'(asui_pkg::MAX_A)) ?
                     asui_pkg::CNT_W'(asui_pkg::MAX_A) : r_cap_a;
        cap_eff_b  = (r_cap_b > asui_pkg::CNT_W'(asui_pkg::MAX_B)) ?
                     asui_pkg::CNT_W'(asui_pkg::MAX_B) : r_cap_b;
        scan_fill  = i_cmd.scan_b  ? r_fill_b  : r_fill_a;
        scan_cap   = i_cmd.scan_b  ? cap_eff_b : cap_eff_a;
        outer_fill = i_cmd.outer_b ? r_fill_b  : r_fill_a;
        scan_data  = i_cmd.scan_b  ? r_rd_b    : r_rd_a;
        outer_data = i_cmd.outer_b ? r_rd_b    : r_rd_a;
        hit        = (scan_data == r_key);
    end

    // status to controller
    always_comb begin
        o_sts.full       = (scan_fill >= scan_cap);
        o_sts.empty      = (scan_fill == '0);
        o_sts.scan_done  = (r_scan_idx >= scan_fill);
        o_sts.hit        = hit;
        o_sts.outer_done = (r_outer_idx >= outer_fill);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // memory port selection per operation
    always_comb begin
        rd_en    = 1'b0;
        rd_b     = i_cmd.scan_b;
        rd_addr  = r_scan_idx;
        wr_en    = 1'b0;
        wr_addr  = scan_fill;
        wr_data  = r_key;
        out_load = 1'b0;
        case (i_cmd.op)
            asui_pkg::DP_SCAN_RD: begin
                rd_en = 1'b1;
            end
            asui_pkg::DP_OUTER_RD: begin
                rd_en   = 1'b1;
                rd_b    = i_cmd.outer_b;
                rd_addr = r_outer_idx;
            end
            asui_pkg::DP_REM_RD: begin
                rd_en   = 1'b1;
                rd_addr = scan_fill - asui_pkg::CNT_W'(1);
            end
            asui_pkg::DP_ADD_WR: begin
                wr_en = 1'b1;
            end
            asui_pkg::DP_REM_WR: begin
                wr_en   = 1'b1;
                wr_addr = asui_pkg::CNT_W'(r_hit_idx);
                wr_data = scan_data;
            end
            asui_pkg::DP_EMIT: begin
                out_load = r_pend_valid;
            end
            asui_pkg::DP_RESULT,
            asui_pkg::DP_FINISH: begin
                out_load = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // member memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (rd_en && !rd_b) begin
            r_rd_a <= mem_a[rd_addr[asui_pkg::ADDR_W_A-1:0]];
        end
        if (wr_en && !i_cmd.scan_b) begin
            mem_a[wr_addr[asui_pkg::ADDR_W_A-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en && rd_b) begin
            r_rd_b <= mem_b[rd_addr[asui_pkg::ADDR_W_B-1:0]];
        end
        if (wr_en && i_cmd.scan_b) begin
            mem_b[wr_addr[asui_pkg::ADDR_W_B-1:0]] <= wr_data;
        end
    end

    // fills, capacities, counters and valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_a     <= '0;
            r_fill_b     <= '0;
            r_cap_a      <= asui_pkg::CAP_RESET;
            r_cap_b      <= asui_pkg::CAP_RESET;
            r_scan_idx   <= '0;
            r_outer_idx  <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    asui_pkg::CFG_CAPACITY_A: r_cap_a <= i_cfg_data;
                    asui_pkg::CFG_CAPACITY_B: r_cap_b <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            case (i_cmd.op)
                asui_pkg::DP_LOAD: begin
                    r_scan_idx   <= '0;
                    r_outer_idx  <= '0;
                    r_pend_valid <= 1'b0;
                end
                asui_pkg::DP_SCAN_CMP: begin
                    r_scan_idx <= r_scan_idx + asui_pkg::CNT_W'(1);
                end
                asui_pkg::DP_OUTER_CLR: begin
                    r_outer_idx <= '0;
                end
                asui_pkg::DP_OUTER_KEY: begin
                    r_outer_idx <= r_outer_idx + asui_pkg::CNT_W'(1);
                    r_scan_idx  <= '0;
                end
                asui_pkg::DP_ADD_WR: begin
                    if (i_cmd.scan_b) begin
                        r_fill_b <= r_fill_b + asui_pkg::CNT_W'(1);
                    end else begin
                        r_fill_a <= r_fill_a + asui_pkg::CNT_W'(1);
                    end
                end
                asui_pkg::DP_REM_RD: begin
                    if (i_cmd.scan_b) begin
                        r_fill_b <= r_fill_b - asui_pkg::CNT_W'(1);
                    end else begin
                        r_fill_a <= r_fill_a - asui_pkg::CNT_W'(1);
                    end
                end
                asui_pkg::DP_EMIT: begin
                    r_pend_valid <= 1'b1;
                end
                default: begin
                end
            endcase
            // result register handshake
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // key, slot, pending item and result payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            asui_pkg::DP_LOAD: begin
                r_key <= i_in_value;
            end
            asui_pkg::DP_OUTER_KEY: begin
                r_key <= outer_data;
            end
            asui_pkg::DP_SCAN_CMP: begin
                if (hit) begin
                    r_hit_idx <= r_scan_idx[asui_pkg::IDX_W-1:0];
                end
            end
            asui_pkg::DP_ADD_WR: begin
                r_hit_idx <= scan_fill[asui_pkg::IDX_W-1:0];
            end
            asui_pkg::DP_EMIT: begin
                r_pend_value <= r_key;
                r_out_status <= asui_pkg::ST_OK;
                r_out_value  <= r_pend_value;
                r_out_idx    <= '0;
                r_out_last   <= 1'b0;
            end
            asui_pkg::DP_RESULT: begin
                r_out_status <= i_cmd.status;
                r_out_value  <= '0;
                r_out_idx    <= i_cmd.use_idx ? r_hit_idx : '0;
                r_out_last   <= 1'b1;
            end
            asui_pkg::DP_FINISH: begin
                r_out_status <= r_pend_valid ? asui_pkg::ST_OK : asui_pkg::ST_EMPTYRES;
                r_out_value  <= r_pend_valid ? r_pend_value : '0;
                r_out_idx    <= '0;
                r_out_last   <= 1'b1;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_count_a <= r_fill_a;
            r_out_count_b <= r_fill_b;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_out_value   = r_out_value;
    assign o_found_index = r_out_idx;
    assign o_count_a     = r_out_count_a;
    assign o_count_b     = r_out_count_b;
    assign o_last        = r_out_last;

endmodule

// ----- rtl/asui_ctrl.sv -----
// asui_ctrl: sequencing state machine of the array set core; drives datapath commands
// from the input item's operation and the datapath status; uses asui_pkg

module asui_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [asui_pkg::FUNC_W-1:0]  i_in_func,
    input  logic                         i_in_set,
    output logic                         o_in_ready,
    input  asui_pkg::t_dp_sts            i_sts,
    output asui_pkg::t_dp_cmd            o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_DISPATCH  = 12'b0000_0000_0010,
        S_SCAN_RD   = 12'b0000_0000_0100,
        S_SCAN_CMP  = 12'b0000_0000_1000,
        S_ADD_WR    = 12'b0000_0001_0000,
        S_REM_RD    = 12'b0000_0010_0000,
        S_REM_WR    = 12'b0000_0100_0000,
        S_RESULT    = 12'b0000_1000_0000,
        S_OUTER_RD  = 12'b0001_0000_0000,
        S_OUTER_KEY = 12'b0010_0000_0000,
        S_EMIT      = 12'b0100_0000_0000,
        S_FINISH    = 12'b1000_0000_0000
    } t_state;

    t_state            r_state, n_state;
    asui_pkg::t_func   r_func, n_func;
    logic              r_set, n_set;
    logic              r_phase, n_phase;
    asui_pkg::t_status r_status, n_status;
    logic              r_use_idx, n_use_idx;

    // set routing: scan set and outer (streamed) set per operation
    logic scan_b;
    logic outer_b;
    always_comb begin
        case (r_func)
            asui_pkg::FN_INTER: begin
                scan_b  = 1'b1;
                outer_b = 1'b0;
            end
            asui_pkg::FN_UNION: begin
                scan_b  = 1'b0;
                outer_b = r_phase;
            end
            default: begin
                scan_b  = r_set;
                outer_b = r_set;
            end
        endcase
    end

    // next state and commands
    always_comb begin
        n_state       = r_state;
        n_func        = r_func;
        n_set         = r_set;
        n_phase       = r_phase;
        n_status      = r_status;
        n_use_idx     = r_use_idx;
        o_in_ready    = 1'b0;
        o_cmd.op      = asui_pkg::DP_NOP;
        o_cmd.scan_b  = scan_b;
        o_cmd.outer_b = outer_b;
        o_cmd.status  = r_status;
        o_cmd.use_idx = r_use_idx;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op  = asui_pkg::DP_LOAD;
                    n_func    = asui_pkg::t_func'(i_in_func);
                    n_set     = i_in_set;
                    n_phase   = 1'b0;
                    n_use_idx = 1'b0;
                    n_state   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (r_func)
                    asui_pkg::FN_ADD: begin
                        if (i_sts.full) begin
                            n_status = asui_pkg::ST_FULL;
                            n_state  = S_RESULT;
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end
                    asui_pkg::FN_REMOVE: begin
                        if (i_sts.empty) begin
                            n_status = asui_pkg::ST_EMPTY;
                            n_state  = S_RESULT;
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end
                    asui_pkg::FN_LOOKUP: begin
                        n_state = S_SCAN_RD;
                    end
                    asui_pkg::FN_LIST,
                    asui_pkg::FN_INTER,
                    asui_pkg::FN_UNION: begin
                        n_state = S_OUTER_RD;
                    end
                    default: begin
                        n_status = asui_pkg::ST_OK;
                        n_state  = S_RESULT;
                    end
                endcase
            end
            // read the next scan entry, or act on a miss once the scan is through
            S_SCAN_RD: begin
                if (i_sts.scan_done) begin
                    case (r_func)
                        asui_pkg::FN_ADD:   n_state = S_ADD_WR;
                        asui_pkg::FN_INTER: n_state = S_OUTER_RD;
                        asui_pkg::FN_UNION: n_state = S_EMIT;
                        default: begin
                            n_status = asui_pkg::ST_NOTFOUND;
                            n_state  = S_RESULT;
                        end
                    endcase
                end else begin
                    o_cmd.op = asui_pkg::DP_SCAN_RD;
                    n_state  = S_SCAN_CMP;
                end
            end
            // compare the returned entry with the key
            S_SCAN_CMP: begin
                o_cmd.op = asui_pkg::DP_SCAN_CMP;
                if (i_sts.hit) begin
                    case (r_func)
                        asui_pkg::FN_ADD: begin
                            n_status = asui_pkg::ST_DUP;
                            n_state  = S_RESULT;
                        end
                        asui_pkg::FN_REMOVE: n_state = S_REM_RD;
                        asui_pkg::FN_INTER:  n_state = S_EMIT;
                        asui_pkg::FN_UNION:  n_state = S_OUTER_RD;
                        default: begin
                            n_status  = asui_pkg::ST_OK;
                            n_use_idx = 1'b1;
                            n_state   = S_RESULT;
                        end
                    endcase
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_ADD_WR: begin
                o_cmd.op  = asui_pkg::DP_ADD_WR;
                n_status  = asui_pkg::ST_OK;
                n_use_idx = 1'b1;
                n_state   = S_RESULT;
            end
            // remove: shrink the fill and fetch the last entry, then move it into the slot
            S_REM_RD: begin
                o_cmd.op = asui_pkg::DP_REM_RD;
                n_state  = S_REM_WR;
            end
            S_REM_WR: begin
                o_cmd.op  = asui_pkg::DP_REM_WR;
                n_status  = asui_pkg::ST_OK;
                n_use_idx = 1'b1;
                n_state   = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = asui_pkg::DP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            // walk the streamed set; union goes on to set b after set a
            S_OUTER_RD: begin
                if (i_sts.outer_done) begin
                    if (r_func == asui_pkg::FN_UNION && !r_phase) begin
                        o_cmd.op = asui_pkg::DP_OUTER_CLR;
                        n_phase  = 1'b1;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    o_cmd.op = asui_pkg::DP_OUTER_RD;
                    n_state  = S_OUTER_KEY;
                end
            end
            S_OUTER_KEY: begin
                o_cmd.op = asui_pkg::DP_OUTER_KEY;
                if (r_func == asui_pkg::FN_LIST ||
                    (r_func == asui_pkg::FN_UNION && !r_phase)) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            // hold back one member so the final one can carry last
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = asui_pkg::DP_EMIT;
                    n_state  = S_OUTER_RD;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.op = asui_pkg::DP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_func    <= asui_pkg::FN_ADD;
            r_set     <= 1'b0;
            r_phase   <= 1'b0;
            r_status  <= asui_pkg::ST_OK;
            r_use_idx <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_func    <= n_func;
            r_set     <= n_set;
            r_phase   <= n_phase;
            r_status  <= n_status;
            r_use_idx <= n_use_idx;
        end
    end

endmodule

// ----- rtl/array_set_with_union_intersection_core.sv -----
// array_set_with_union_intersection_core: top level of the two-set array core
// depends on asui_pkg, asui_in_if, asui_out_if, asui_ctrl and asui_dp

// Two unordered sets A and B of signed 32-bit members, 32 slots each, with add, remove,
// lookup, list, intersection and union. One input item is worked on at a time; the next
// is taken once the controller is back in idle, while the final result may still sit in
// the output register. Each set memory has a single read port with registered data, so
// a search reads each member that it visits in one state and compares it in another.
// The user must write capacities through the configuration port only while the block is
// idle; the block itself does not enforce this. A capacity above 32 acts as 32.
// Reset needs no clearing pass: slots at or above a set's fill are never read.

module array_set_with_union_intersection_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [asui_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [asui_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    asui_in_if.sink                               i_in_ch,
    asui_out_if.source                            o_out_ch
);

    asui_pkg::t_dp_cmd dp_cmd;
    asui_pkg::t_dp_sts dp_sts;

    // sequencer
    asui_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_in_func  (i_in_ch.func),
        .i_in_set   (i_in_ch.which_set),
        .o_in_ready (i_in_ch.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // storage, compare and result register
    asui_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (dp_cmd),
        .i_in_value    (i_in_ch.member_value),
        .i_out_ready   (o_out_ch.ready),
        .o_sts         (dp_sts),
        .o_out_valid   (o_out_ch.valid),
        .o_status      (o_out_ch.status),
        .o_out_value   (o_out_ch.out_value),
        .o_found_index (o_out_ch.found_index),
        .o_count_a     (o_out_ch.count_a),
        .o_count_b     (o_out_ch.count_b),
        .o_last        (o_out_ch.last)
    );

endmodule

// ----- bench/asui_result_checker.sv -----
// asui_result_checker: watches the item and result channels of the array set core,
// keeps its own copy of both sets and compares every result against the prediction
// depends on asui_pkg, asui_in_if and asui_out_if

module asui_result_checker
    import asui_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    asui_in_if                    i_in_mon,
    asui_out_if                   i_out_mon,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int STREAM_LIMIT = 64;
    localparam int REPORT_LIMIT = 50;

    // one predicted result item
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  value;
        logic [IDX_W-1:0]  slot;
        logic [CNT_W-1:0]  cnt_a;
        logic [CNT_W-1:0]  cnt_b;
        logic              last;
    } t_set_result;

    // shadow copy of both sets and their capacity registers
    logic [VAL_W-1:0]  set_a [MAX_A];
    logic [VAL_W-1:0]  set_b [MAX_B];
    int                fill_a;
    int                fill_b;
    logic [CNT_W-1:0]  cap_a;
    logic [CNT_W-1:0]  cap_b;

    t_set_result       pending_results [$];
    int                fail_count;

    assign o_fail_count = fail_count;

    // slot of a member in one set, -1 when absent
    function automatic int slot_in(logic use_b, logic [VAL_W-1:0] v);
        int i;
        if (use_b) begin
            for (i = 0; i < fill_b; i++)
                if (set_b[i] == v) return i;
        end else begin
            for (i = 0; i < fill_a; i++)
                if (set_a[i] == v) return i;
        end
        return -1;
    endfunction

    // queue one result item, counts taken after the step
    function automatic void expect_result(logic [STAT_W-1:0] st, logic [VAL_W-1:0] val,
                                          int slot, logic last_flag);
        t_set_result r;
        r.status = st;
        r.value  = val;
        r.slot   = IDX_W'(slot);
        r.cnt_a  = CNT_W'(fill_a);
        r.cnt_b  = CNT_W'(fill_b);
        r.last   = last_flag;
        pending_results.push_back(r);
    endfunction

    // apply one accepted item to the shadow sets and queue what it must produce
    function automatic void apply_set_op(logic [FUNC_W-1:0] fn, logic use_b,
                                         logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] stream [$];
        int eff_cap;
        int fill;
        int hit;
        int i;
        int n;

        eff_cap = use_b ? int'(cap_b) : int'(cap_a);
        if (use_b && eff_cap > MAX_B) eff_cap = MAX_B;
        if (!use_b && eff_cap > MAX_A) eff_cap = MAX_A;
        fill = use_b ? fill_b : fill_a;

        case (fn)
            FN_ADD: begin
                if (fill >= eff_cap) begin
                    expect_result(ST_FULL, '0, 0, 1'b1);
                end else if (slot_in(use_b, v) >= 0) begin
                    expect_result(ST_DUP, '0, 0, 1'b1);
                end else begin
                    if (use_b) begin
                        set_b[fill_b] = v;
                        fill_b++;
                    end else begin
                        set_a[fill_a] = v;
                        fill_a++;
                    end
                    expect_result(ST_OK, '0, fill, 1'b1);
                end
            end
            FN_REMOVE: begin
                hit = slot_in(use_b, v);
                if (fill == 0) begin
                    expect_result(ST_EMPTY, '0, 0, 1'b1);
                end else if (hit < 0) begin
                    expect_result(ST_NOTFOUND, '0, 0, 1'b1);
                end else begin
                    // last entry moves into the freed slot
                    if (use_b) begin
                        fill_b--;
                        set_b[hit] = set_b[fill_b];
                    end else begin
                        fill_a--;
                        set_a[hit] = set_a[fill_a];
                    end
                    expect_result(ST_OK, '0, hit, 1'b1);
                end
            end
            FN_LOOKUP: begin
                hit = slot_in(use_b, v);
                if (hit < 0) expect_result(ST_NOTFOUND, '0, 0, 1'b1);
                else         expect_result(ST_OK, '0, hit, 1'b1);
            end
            FN_LIST, FN_INTER, FN_UNION: begin
                if (fn == FN_LIST) begin
                    for (i = 0; i < fill; i++)
                        stream.push_back(use_b ? set_b[i] : set_a[i]);
                end else if (fn == FN_INTER) begin
                    for (i = 0; i < fill_a; i++)
                        if (slot_in(1'b1, set_a[i]) >= 0) stream.push_back(set_a[i]);
                end else begin
                    for (i = 0; i < fill_a; i++)
                        stream.push_back(set_a[i]);
                    for (i = 0; i < fill_b; i++)
                        if (slot_in(1'b0, set_b[i]) < 0) stream.push_back(set_b[i]);
                end
                // streams are cut at the limit, the last kept item carries last
                n = (stream.size() > STREAM_LIMIT) ? STREAM_LIMIT : stream.size();
                if (n == 0) begin
                    expect_result(ST_EMPTYRES, '0, 0, 1'b1);
                end else begin
                    for (i = 0; i < n; i++)
                        expect_result(ST_OK, stream[i], 0, i == n - 1);
                end
            end
            default: begin
                // spare codes change nothing
                expect_result(ST_OK, '0, 0, 1'b1);
            end
        endcase
    endfunction

    // compare one field, count and report a mismatch
    function automatic void check_field(string field, logic [VAL_W-1:0] want,
                                        logic [VAL_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
        end
    endfunction

    // watch both channels and the register port
    always @(posedge i_clk) begin : watch
        t_set_result want;
        if (!i_rst_n) begin
            fill_a     = 0;
            fill_b     = 0;
            cap_a      = CAP_RESET;
            cap_b      = CAP_RESET;
            fail_count = 0;
            pending_results.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_CAPACITY_A)      cap_a = i_cfg_data;
                else if (i_cfg_idx == CFG_CAPACITY_B) cap_b = i_cfg_data;
            end
            // a result leaving at the same edge belongs to the item before
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $error("result with no item waiting: status %0d value 0x%0h",
                               i_out_mon.status, i_out_mon.out_value);
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", VAL_W'(want.status), VAL_W'(i_out_mon.status));
                    check_field("out_value", want.value, i_out_mon.out_value);
                    check_field("found_index", VAL_W'(want.slot),
                                VAL_W'(i_out_mon.found_index));
                    check_field("count_a", VAL_W'(want.cnt_a), VAL_W'(i_out_mon.count_a));
                    check_field("count_b", VAL_W'(want.cnt_b), VAL_W'(i_out_mon.count_b));
                    check_field("last", VAL_W'(want.last), VAL_W'(i_out_mon.last));
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                apply_set_op(i_in_mon.func, i_in_mon.which_set, i_in_mon.member_value);
            o_pending <= pending_results.size();
        end
    end

endmodule

// ----- bench/tb_array_set_with_union_intersection_core.sv -----
// tb_array_set_with_union_intersection_core: clock, reset, item and register stimulus
// and the final verdict for the array set core; checking lives in asui_result_checker
// depends on asui_pkg, asui_in_if, asui_out_if, asui_result_checker and the core

module tb_array_set_with_union_intersection_core;
    import asui_pkg::*;

    // func codes the block does not use
    localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;
    localparam int                POOL_SIZE  = 64;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    bit                    no_idle;
    bit                    hold_request;
    logic [VAL_W-1:0]      member_pool [POOL_SIZE];

    asui_in_if  in_ch ();
    asui_out_if out_ch ();

    array_set_with_union_intersection_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    asui_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 i_clk = ~i_clk;

    // hard stop in case the block hangs
    initial begin
        #16000000;
        $display("Simulation FAILED");
        $finish;
    end

    // idle length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [VAL_W-1:0] pick_member();
        if ($urandom_range(99) < 80) return member_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom();
    endfunction

    // result side: random stalls, and one long hold-off on request
    initial begin : result_sink
        int gap;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(400, 250)) @(posedge i_clk);
                hold_request = 1'b0;
                out_ch.ready <= 1'b1;
            end else begin
                gap = idle_len();
                if (gap == 0) begin
                    out_ch.ready <= 1'b1;
                end else begin
                    out_ch.ready <= 1'b0;
                    repeat (gap - 1) @(posedge i_clk);
                end
            end
        end
    end

    // offer one item, wait for the handshake, then maybe idle with junk payload
    task automatic send_item(logic [FUNC_W-1:0] fn, logic which, logic [VAL_W-1:0] v);
        int gap;
        in_ch.valid        <= 1'b1;
        in_ch.func         <= fn;
        in_ch.which_set    <= which;
        in_ch.member_value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        gap = idle_len();
        if (gap > 0) begin
            in_ch.valid        <= 1'b0;
            in_ch.func         <= FUNC_W'($urandom());
            in_ch.which_set    <= 1'($urandom());
            in_ch.member_value <= $urandom();
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering until every predicted result is out, plus a short settle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [CFG_DATA_W-1:0] cap_a, logic [CFG_DATA_W-1:0] cap_b);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_CAPACITY_A;
        cfg_data <= cap_a;
        @(posedge i_clk);
        cfg_idx  <= CFG_CAPACITY_B;
        cfg_data <= cap_b;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // fill A and B to the top with disjoint members, then stream them all
    task automatic fill_both_sets();
        int k;
        int off;
        off = $urandom_range(31);
        for (k = 0; k < 32; k++)
            send_item(FN_ADD, 1'b0, member_pool[(k + off) % 32]);
        off = $urandom_range(31);
        for (k = 0; k < 32; k++)
            send_item(FN_ADD, 1'b1, member_pool[32 + (k + off) % 32]);
        send_item(FN_UNION, 1'($urandom()), pick_member());
        send_item(FN_INTER, 1'($urandom()), pick_member());
        send_item(FN_LIST, 1'b0, pick_member());
        send_item(FN_LIST, 1'b1, pick_member());
    endtask

    // random mix of operations, add share set per phase
    task automatic run_random_phase(int n_items, int add_pct, int hold_at);
        logic [FUNC_W-1:0] fn;
        int k;
        int r;
        for (k = 0; k < n_items; k++) begin
            if (k == hold_at) hold_request = 1'b1;
            r = $urandom_range(99);
            if (r < add_pct) begin
                fn = FN_ADD;
            end else begin
                r = $urandom_range(99);
                if (r < 28)      fn = FN_REMOVE;
                else if (r < 52) fn = FN_LOOKUP;
                else if (r < 70) fn = FN_LIST;
                else if (r < 82) fn = FN_INTER;
                else if (r < 94) fn = FN_UNION;
                else if (r < 97) fn = FN_SPARE_6;
                else             fn = FN_SPARE_7;
            end
            send_item(fn, 1'($urandom()), pick_member());
            if ($urandom_range(99) < 4) wait_idle();
        end
    endtask

    initial begin : stimulus
        int k;
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_CAPACITY_A;
        cfg_data           <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.func         <= FN_ADD;
        in_ch.which_set    <= 1'b0;
        in_ch.member_value <= '0;
        no_idle      = 1'b0;
        hold_request = 1'b0;

        // extremes first, then random members
        member_pool[0] = 32'h8000_0000;
        member_pool[1] = 32'h7fff_ffff;
        member_pool[2] = 32'h0000_0000;
        member_pool[3] = 32'hffff_ffff;
        for (k = 4; k < POOL_SIZE; k++)
            member_pool[k] = $urandom();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty sets: lookup, remove, empty streams, spare codes
        send_item(FN_LOOKUP, 1'b0, 32'h0000_0000);
        send_item(FN_REMOVE, 1'b0, 32'h0000_0000);
        send_item(FN_LIST, 1'b0, 32'h0000_0000);
        send_item(FN_INTER, 1'b0, 32'h0000_0000);
        send_item(FN_UNION, 1'b0, 32'h0000_0000);
        send_item(FN_SPARE_6, 1'b1, 32'hffff_ffff);
        send_item(FN_SPARE_7, 1'b0, 32'h8000_0000);

        // extreme members, a duplicate, overlapping sets
        send_item(FN_ADD, 1'b0, 32'h8000_0000);
        send_item(FN_ADD, 1'b0, 32'h7fff_ffff);
        send_item(FN_ADD, 1'b0, 32'h0000_0000);
        send_item(FN_ADD, 1'b0, 32'hffff_ffff);
        send_item(FN_ADD, 1'b0, 32'h0000_0000);
        send_item(FN_ADD, 1'b1, 32'hffff_ffff);
        send_item(FN_ADD, 1'b1, 32'h7fff_ffff);
        send_item(FN_ADD, 1'b1, 32'h0000_0005);
        send_item(FN_LOOKUP, 1'b0, 32'h7fff_ffff);
        send_item(FN_LOOKUP, 1'b1, 32'h1234_5678);
        send_item(FN_LIST, 1'b0, 32'h0000_0000);
        send_item(FN_INTER, 1'b1, 32'h0000_0000);
        send_item(FN_UNION, 1'b1, 32'h0000_0000);

        // remove from the front moves the last entry, then an absent member
        send_item(FN_REMOVE, 1'b0, 32'h8000_0000);
        send_item(FN_REMOVE, 1'b1, 32'h0bad_0000);
        send_item(FN_LIST, 1'b0, 32'h0000_0000);

        // capacity below fill and capacity zero
        set_capacity(6'd2, 6'd0);
        send_item(FN_ADD, 1'b0, 32'h0000_0001);
        send_item(FN_ADD, 1'b1, 32'h0000_0001);

        // empty B, then both sets full with disjoint members, above-depth capacity
        set_capacity(6'd63, 6'd63);
        send_item(FN_REMOVE, 1'b1, 32'hffff_ffff);
        send_item(FN_REMOVE, 1'b1, 32'h7fff_ffff);
        send_item(FN_REMOVE, 1'b1, 32'h0000_0005);
        fill_both_sets();
        run_random_phase(64, 30, -1);

        // a phase with no idling on either side
        no_idle = 1'b1;
        set_capacity(6'd32, 6'd32);
        run_random_phase(64, 45, -1);
        no_idle = 1'b0;

        set_capacity(6'd0, 6'd17);
        run_random_phase(64, 50, -1);

        // long hold-off on the result side while items keep coming
        set_capacity(6'd1, 6'd32);
        run_random_phase(64, 35, 6);

        set_capacity(CFG_DATA_W'($urandom_range(63)), CFG_DATA_W'($urandom_range(63)));
        run_random_phase(64, 45, -1);

        set_capacity(6'd32, 6'd5);
        run_random_phase(64, 55, -1);

        // drain and make sure nothing stray follows
        wait_idle();
        repeat (64) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- array_set_with_union_intersection_core.f -----
rtl/asui_pkg.sv
rtl/asui_in_if.sv
rtl/asui_out_if.sv
rtl/asui_dp.sv
rtl/asui_ctrl.sv
rtl/array_set_with_union_intersection_core.sv
bench/asui_result_checker.sv
bench/tb_array_set_with_union_intersection_core.sv
